// ===== design/cesd_pkg.sv =====
// Shared types for the C string escape decoder.
// Holds the result-group struct passed from the decoder to the output serializer.
// No dependencies.
`default_nettype none

package cesd_pkg;

  // Most bytes one input beat can expand into (a four-byte UTF-8 sequence).
  localparam int unsigned MaxBeats = 4;
  localparam int unsigned BeatCntW = $clog2(MaxBeats + 1);

  // Results caused by one input beat, oldest byte in bytes[0].
  typedef struct packed {
    logic [BeatCntW-1:0]       nbeats;   // 0 means nothing to send
    logic [MaxBeats-1:0][7:0]  bytes;
    logic                      has_byte; // 0 only for the empty end-of-string beat
    logic                      done;     // group closes the string
    logic                      status;   // error seen in the string
  } res_grp_t;

endpackage

`default_nettype wire

// ===== design/c_string_escape_decoder.sv =====
// A byte accepted into the stage-1 register is decoded combinationally and its result
// group loaded into the serializer. Throughput: one input byte per cycle while each
// byte gives at most one result beat and out_tready is high; multi-byte UTF-8 stalls input.
// Reset: synchronous, active low; clears the parse state, the sticky error and both
// pipeline valids.
// Depends on cesd_pkg, cesd_decode and cesd_serializer.
`default_nettype none

module c_string_escape_decoder (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_tvalid,
  output logic            in_tready,
  input  wire logic [7:0] in_tdata,   // [7:0] in_byte
  input  wire logic       in_tlast,   // is_last
  output logic            out_tvalid,
  input  wire logic       out_tready,
  output logic [7:0]      out_tdata,  // [7:0] out_byte
  output logic [1:0]      out_tuser,  // [0] byte_valid, [1] status
  output logic            out_tlast   // string_done
);

  logic               s1_valid_r;
  logic [7:0]         s1_byte_r;
  logic               s1_last_r;
  logic               s1_adv;
  logic               ser_ready;
  logic               ser_load;
  cesd_pkg::res_grp_t grp;

  // Bytes with no result retire without touching the serializer
  assign s1_adv    = s1_valid_r && ((grp.nbeats == '0) || ser_ready);
  assign ser_load  = s1_valid_r && (grp.nbeats != '0) && ser_ready;
  assign in_tready = !s1_valid_r || s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_byte_r <= in_tdata;
      s1_last_r <= in_tlast;
    end
  end

  cesd_decode u_decode (
    .clk    (clk),
    .rst_n  (rst_n),
    .byte_i (s1_byte_r),
    .last_i (s1_last_r),
    .step_i (s1_adv),
    .grp_o  (grp)
  );

  cesd_serializer u_serializer (
    .clk        (clk),
    .rst_n      (rst_n),
    .load_i     (ser_load),
    .grp_i      (grp),
    .ready_o    (ser_ready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

`default_nettype wire

// ===== design/cesd_decode.sv =====
// Escape parser: holds the parse state and turns one byte into a result group.
// Depends on cesd_pkg for res_grp_t.
`default_nettype none

module cesd_decode (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic [7:0]        byte_i,
  input  wire logic              last_i,
  input  wire logic              step_i,   // commit this byte, advance the state
  output cesd_pkg::res_grp_t     grp_o
);

  typedef enum logic [2:0] {
    MODE_IDLE,
    MODE_ESC,
    MODE_OCT,
    MODE_HEXA,
    MODE_HEXB,
    MODE_HEXC,
    MODE_UNI
  } mode_t;

  localparam logic [7:0] ChBsl = 8'h5C;

  mode_t       mode_r, mode_nxt;
  logic [31:0] acc_r, acc_nxt;
  logic [3:0]  cnt_r, cnt_nxt;
  logic        wide_r, wide_nxt;
  logic        err_r, err_nxt;

  logic        is_hex, is_oct;
  logic [3:0]  hv;
  logic        fail_s, pre_en, tail_en, tail_emit, utf_en;
  logic        status_s;
  logic [7:0]  pre_val;
  logic [8:0]  oct_sum;
  logic [3:0]  cnt_inc, need;
  logic [31:0] uacc;
  logic        bad_cp;
  logic        letter_hit;
  logic [7:0]  letter_val;
  logic [cesd_pkg::BeatCntW-1:0] nb;
  logic [cesd_pkg::MaxBeats-1:0][7:0] bytes;

  always_comb begin
    is_oct = (byte_i >= "0") && (byte_i <= "7");
    is_hex = ((byte_i >= "0") && (byte_i <= "9")) ||
             ((byte_i >= "a") && (byte_i <= "f")) ||
             ((byte_i >= "A") && (byte_i <= "F"));
    hv     = ((byte_i >= "0") && (byte_i <= "9")) ? byte_i[3:0] : byte_i[3:0] + 4'd9;
    oct_sum = {acc_r[5:0], byte_i[2:0]};
    cnt_inc = cnt_r + 4'd1;
    need    = wide_r ? 4'd8 : 4'd4;
    uacc    = {acc_r[27:0], hv};
    bad_cp  = ((uacc < 32'h0000_00A0) && (uacc != 32'h24) && (uacc != 32'h40) &&
               (uacc != 32'h60)) ||
              ((uacc >= 32'h0000_D800) && (uacc <= 32'h0000_DFFF)) ||
              (uacc > 32'h0010_FFFF);
  end

  // One-letter escapes
  always_comb begin
    letter_hit = 1'b1;
    unique case (byte_i)
      "?":     letter_val = 8'h3F;
      "'":     letter_val = 8'h27;
      "\"":    letter_val = 8'h22;
      ChBsl:   letter_val = 8'h5C;
      "a":     letter_val = 8'h07;
      "b":     letter_val = 8'h08;
      "f":     letter_val = 8'h0C;
      "n":     letter_val = 8'h0A;
      "r":     letter_val = 8'h0D;
      "t":     letter_val = 8'h09;
      "v":     letter_val = 8'h0B;
      default: begin
        letter_hit = 1'b0;
        letter_val = 8'h00;
      end
    endcase
  end

  always_comb begin
    mode_nxt  = mode_r;
    acc_nxt   = acc_r;
    cnt_nxt   = cnt_r;
    wide_nxt  = wide_r;
    err_nxt   = err_r;
    fail_s    = 1'b0;
    pre_en    = 1'b0;
    pre_val   = 8'h00;
    tail_en   = 1'b0;
    tail_emit = 1'b0;
    utf_en    = 1'b0;

    if (!err_r) begin
      unique case (mode_r)
        MODE_ESC: begin
          mode_nxt = MODE_IDLE;
          acc_nxt  = '0;
          cnt_nxt  = '0;
          wide_nxt = 1'b0;
          if (letter_hit) begin
            pre_en  = 1'b1;
            pre_val = letter_val;
          end else if (byte_i == "x") begin
            if (last_i) fail_s = 1'b1;
            else mode_nxt = MODE_HEXA;
          end else if ((byte_i == "u") || (byte_i == "U")) begin
            if (last_i) begin
              fail_s = 1'b1;
            end else begin
              mode_nxt = MODE_UNI;
              wide_nxt = (byte_i == "U");
            end
          end else if (is_oct) begin
            if (last_i) begin
              pre_en  = 1'b1;
              pre_val = {5'd0, byte_i[2:0]};
            end else begin
              mode_nxt = MODE_OCT;
              acc_nxt  = {29'd0, byte_i[2:0]};
              cnt_nxt  = 4'd1;
            end
          end else begin
            fail_s = 1'b1;
          end
        end
        MODE_OCT: begin
          if (is_oct) begin
            if (cnt_inc >= 4'd3) begin
              if (oct_sum[8]) begin
                fail_s = 1'b1;
              end else begin
                pre_en   = 1'b1;
                pre_val  = oct_sum[7:0];
                mode_nxt = MODE_IDLE;
                acc_nxt  = '0;
                cnt_nxt  = '0;
              end
            end else if (last_i) begin
              pre_en   = 1'b1;
              pre_val  = oct_sum[7:0];
              mode_nxt = MODE_IDLE;
              acc_nxt  = '0;
              cnt_nxt  = '0;
            end else begin
              acc_nxt = {23'd0, oct_sum};
              cnt_nxt = cnt_inc;
            end
          end else begin
            pre_en   = 1'b1;
            pre_val  = acc_r[7:0];
            mode_nxt = MODE_IDLE;
            acc_nxt  = '0;
            cnt_nxt  = '0;
            tail_en  = 1'b1;
          end
        end
        MODE_HEXA: begin
          if (!is_hex) begin
            fail_s = 1'b1;
          end else if (last_i) begin
            pre_en   = 1'b1;
            pre_val  = {4'd0, hv};
            mode_nxt = MODE_IDLE;
          end else begin
            acc_nxt  = {28'd0, hv};
            cnt_nxt  = 4'd1;
            mode_nxt = MODE_HEXB;
          end
        end
        MODE_HEXB: begin
          if (is_hex) begin
            if (last_i) begin
              pre_en   = 1'b1;
              pre_val  = {acc_r[3:0], hv};
              mode_nxt = MODE_IDLE;
            end else begin
              acc_nxt  = {24'd0, acc_r[3:0], hv};
              cnt_nxt  = 4'd2;
              mode_nxt = MODE_HEXC;
            end
          end else begin
            pre_en   = 1'b1;
            pre_val  = acc_r[7:0];
            mode_nxt = MODE_IDLE;
            acc_nxt  = '0;
            cnt_nxt  = '0;
            tail_en  = 1'b1;
          end
        end
        MODE_HEXC: begin
          if (is_hex) begin
            fail_s = 1'b1;
          end else begin
            pre_en   = 1'b1;
            pre_val  = acc_r[7:0];
            mode_nxt = MODE_IDLE;
            acc_nxt  = '0;
            cnt_nxt  = '0;
            tail_en  = 1'b1;
          end
        end
        MODE_UNI: begin
          if (!is_hex) begin
            fail_s = 1'b1;
          end else if (cnt_inc < need) begin
            if (last_i) begin
              fail_s = 1'b1;
            end else begin
              acc_nxt = uacc;
              cnt_nxt = cnt_inc;
            end
          end else if (bad_cp) begin
            fail_s = 1'b1;
          end else begin
            utf_en   = 1'b1;
            mode_nxt = MODE_IDLE;
            acc_nxt  = '0;
            cnt_nxt  = '0;
            wide_nxt = 1'b0;
          end
        end
        default: begin
          mode_nxt = MODE_IDLE;
          acc_nxt  = '0;
          cnt_nxt  = '0;
          wide_nxt = 1'b0;
          tail_en  = 1'b1;
        end
      endcase

      // Delimiting or plain byte: a backslash opens an escape unless it ends the string
      if (tail_en) begin
        if ((byte_i == ChBsl) && !last_i) mode_nxt = MODE_ESC;
        else tail_emit = 1'b1;
      end

      if (fail_s) begin
        mode_nxt = MODE_IDLE;
        acc_nxt  = '0;
        cnt_nxt  = '0;
        wide_nxt = 1'b0;
        err_nxt  = 1'b1;
      end
    end

    status_s = last_i & err_nxt;

    if (last_i) begin
      mode_nxt = MODE_IDLE;
      acc_nxt  = '0;
      cnt_nxt  = '0;
      wide_nxt = 1'b0;
      err_nxt  = 1'b0;
    end
  end

  // Assemble the result bytes
  always_comb begin
    bytes = '0;
    nb    = '0;
    if (utf_en) begin
      if (uacc[20:0] < 21'h80) begin
        nb       = 3'd1;
        bytes[0] = {1'b0, uacc[6:0]};
      end else if (uacc[20:0] < 21'h800) begin
        nb       = 3'd2;
        bytes[0] = {3'b110, uacc[10:6]};
        bytes[1] = {2'b10, uacc[5:0]};
      end else if (uacc[20:0] < 21'h10000) begin
        nb       = 3'd3;
        bytes[0] = {4'b1110, uacc[15:12]};
        bytes[1] = {2'b10, uacc[11:6]};
        bytes[2] = {2'b10, uacc[5:0]};
      end else begin
        nb       = 3'd4;
        bytes[0] = {5'b11110, uacc[20:18]};
        bytes[1] = {2'b10, uacc[17:12]};
        bytes[2] = {2'b10, uacc[11:6]};
        bytes[3] = {2'b10, uacc[5:0]};
      end
    end else begin
      nb       = cesd_pkg::BeatCntW'({1'b0, pre_en} + {1'b0, tail_emit});
      bytes[0] = pre_en ? pre_val : (tail_emit ? byte_i : 8'h00);
      bytes[1] = byte_i;
    end

    grp_o.status   = status_s;
    grp_o.done     = last_i;
    grp_o.has_byte = (nb != '0);
    grp_o.bytes    = bytes;
    // Nothing decoded on the last byte: still close the string with one empty beat
    if (last_i && (nb == '0)) grp_o.nbeats = cesd_pkg::BeatCntW'(1);
    else grp_o.nbeats = nb;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_IDLE;
      acc_r  <= '0;
      cnt_r  <= '0;
      wide_r <= 1'b0;
      err_r  <= 1'b0;
    end else if (step_i) begin
      mode_r <= mode_nxt;
      acc_r  <= acc_nxt;
      cnt_r  <= cnt_nxt;
      wide_r <= wide_nxt;
      err_r  <= err_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== design/cesd_serializer.sv =====
// Result register and serializer: sends a result group out one beat at a time.
// Depends on cesd_pkg for res_grp_t.
`default_nettype none

module cesd_serializer (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               load_i,
  input  cesd_pkg::res_grp_t      grp_i,
  output logic                    ready_o,
  output logic                    out_tvalid,
  input  wire logic               out_tready,
  output logic [7:0]              out_tdata,  // [7:0] out_byte
  output logic [1:0]              out_tuser,  // [0] byte_valid, [1] status
  output logic                    out_tlast   // string_done
);

  logic [cesd_pkg::BeatCntW-1:0]      rem_r;
  logic [cesd_pkg::MaxBeats-1:0][7:0] bytes_r;
  logic                               has_byte_r;
  logic                               done_r;
  logic                               status_r;
  logic                               final_beat;

  assign final_beat = (rem_r == cesd_pkg::BeatCntW'(1));
  assign out_tvalid = (rem_r != '0);
  assign ready_o    = (rem_r == '0) || (out_tready && final_beat);
  assign out_tdata  = bytes_r[0];
  assign out_tlast  = done_r && final_beat;
  assign out_tuser  = {status_r && final_beat, has_byte_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r <= '0;
    end else if (load_i) begin
      rem_r <= grp_i.nbeats;
    end else if (out_tvalid && out_tready) begin
      rem_r <= rem_r - cesd_pkg::BeatCntW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (load_i) begin
      bytes_r    <= grp_i.bytes;
      has_byte_r <= grp_i.has_byte;
      done_r     <= grp_i.done;
      status_r   <= grp_i.status;
    end else if (out_tvalid && out_tready) begin
      // advance to the next byte of the group
      bytes_r <= bytes_r >> 8;
    end
  end

endmodule

`default_nettype wire

// ===== dv/tb_top.sv =====
// Self-checking testbench for c_string_escape_decoder: directed strings, then random ones.
// Holds a scoreboard class that predicts the decoded byte stream; depends on the DUT only.
`timescale 1ns / 100ps

module tb_top;

  localparam int          ItemTarget = 480;
  localparam int          QuietLimit = 2000;
  localparam int          DrainCycles = 16;
  localparam int          IdlePct = 19;
  localparam logic [7:0]  Bslash = 8'h5C;
  localparam logic [31:0] CpLowest = 32'h0000_00A0;
  localparam logic [31:0] CpDollar = 32'h0000_0024;
  localparam logic [31:0] CpAt = 32'h0000_0040;
  localparam logic [31:0] CpGrave = 32'h0000_0060;
  localparam logic [31:0] CpSurLo = 32'h0000_D800;
  localparam logic [31:0] CpSurHi = 32'h0000_DFFF;
  localparam logic [31:0] CpMax = 32'h0010_FFFF;
  localparam logic [31:0] OctLimit = 32'd256;

  typedef enum logic [2:0] {
    ESC_IDLE, ESC_OPEN, ESC_OCT, ESC_HEX0, ESC_HEX1, ESC_HEX2, ESC_UNI
  } esc_mode_e;

  typedef struct packed {
    logic [7:0] data;
    logic       byte_valid;
    logic       status;
    logic       done;
  } dec_beat_t;

  class decode_scoreboard;
    esc_mode_e   mode;
    logic [31:0] acc;
    logic [3:0]  ndig;
    bit          wide;
    bit          err;
    dec_beat_t   decoded_q[$];
    int          errors;

    function new();
      errors = 0;
      clear_esc();
      err = 0;
    endfunction

    function void clear_esc();
      mode = ESC_IDLE;
      acc = '0;
      ndig = '0;
      wide = 0;
    endfunction

    function void fail_string();
      clear_esc();
      err = 1;
    endfunction

    function void push_byte(logic [7:0] v);
      decoded_q.push_back('{data: v, byte_valid: 1'b1, status: 1'b0, done: 1'b0});
    endfunction

    function logic [4:0] hex_nibble(logic [7:0] b);
      if (b >= "0" && b <= "9") return {1'b0, b[3:0]};
      if ((b >= "a" && b <= "f") || (b >= "A" && b <= "F")) return 5'(b[3:0] + 4'd9);
      return 5'd16;
    endfunction

    function void plain_byte(logic [7:0] b, bit last);
      if (b == Bslash && !last) mode = ESC_OPEN;
      else push_byte(b);
    endfunction

    // One source byte against the current parse state.
    function void decode_byte(logic [7:0] b, bit last);
      logic [4:0]  hv;
      logic [31:0] cp;
      hv = hex_nibble(b);
      case (mode)
        ESC_OPEN: begin
          clear_esc();
          case (b)
            8'h3F, 8'h27, 8'h22, Bslash: push_byte(b);
            "a": push_byte(8'h07);
            "b": push_byte(8'h08);
            "f": push_byte(8'h0C);
            "n": push_byte(8'h0A);
            "r": push_byte(8'h0D);
            "t": push_byte(8'h09);
            "v": push_byte(8'h0B);
            "x": begin
              if (last) fail_string();
              else mode = ESC_HEX0;
            end
            "u", "U": begin
              if (last) begin
                fail_string();
              end else begin
                mode = ESC_UNI;
                wide = (b == "U");
              end
            end
            default: begin
              if (b >= "0" && b <= "7") begin
                if (last) begin
                  push_byte({5'd0, b[2:0]});
                end else begin
                  mode = ESC_OCT;
                  acc = {29'd0, b[2:0]};
                  ndig = 4'd1;
                end
              end else begin
                fail_string();
              end
            end
          endcase
        end
        ESC_OCT: begin
          if (b >= "0" && b <= "7") begin
            acc = (acc << 3) | {29'd0, b[2:0]};
            ndig = ndig + 4'd1;
            if (ndig >= 4'd3) begin
              if (acc >= OctLimit) begin
                fail_string();
              end else begin
                cp = acc;
                clear_esc();
                push_byte(cp[7:0]);
              end
            end else if (last) begin
              cp = acc;
              clear_esc();
              push_byte(cp[7:0]);
            end
          end else begin
            cp = acc;
            clear_esc();
            push_byte(cp[7:0]);
            plain_byte(b, last);
          end
        end
        ESC_HEX0: begin
          if (hv > 5'd15) begin
            fail_string();
          end else if (last) begin
            clear_esc();
            push_byte({4'd0, hv[3:0]});
          end else begin
            acc = {28'd0, hv[3:0]};
            ndig = 4'd1;
            mode = ESC_HEX1;
          end
        end
        ESC_HEX1: begin
          if (hv <= 5'd15) begin
            acc = {24'd0, acc[3:0], hv[3:0]};
            ndig = 4'd2;
            mode = ESC_HEX2;
            if (last) begin
              cp = acc;
              clear_esc();
              push_byte(cp[7:0]);
            end
          end else begin
            cp = acc;
            clear_esc();
            push_byte(cp[7:0]);
            plain_byte(b, last);
          end
        end
        ESC_HEX2: begin
          if (hv <= 5'd15) begin
            fail_string();
          end else begin
            cp = acc;
            clear_esc();
            push_byte(cp[7:0]);
            plain_byte(b, last);
          end
        end
        ESC_UNI: begin
          if (hv > 5'd15) begin
            fail_string();
          end else begin
            acc = {acc[27:0], hv[3:0]};
            ndig = ndig + 4'd1;
            if (ndig < (wide ? 4'd8 : 4'd4)) begin
              if (last) fail_string();
            end else begin
              cp = acc;
              if ((cp < CpLowest && cp != CpDollar && cp != CpAt && cp != CpGrave) ||
                  (cp >= CpSurLo && cp <= CpSurHi) || cp > CpMax) begin
                fail_string();
              end else begin
                clear_esc();
                if (cp < 32'h80) begin
                  push_byte(cp[7:0]);
                end else if (cp < 32'h800) begin
                  push_byte({3'b110, cp[10:6]});
                  push_byte({2'b10, cp[5:0]});
                end else if (cp < 32'h10000) begin
                  push_byte({4'b1110, cp[15:12]});
                  push_byte({2'b10, cp[11:6]});
                  push_byte({2'b10, cp[5:0]});
                end else begin
                  push_byte({5'b11110, cp[20:18]});
                  push_byte({2'b10, cp[17:12]});
                  push_byte({2'b10, cp[11:6]});
                  push_byte({2'b10, cp[5:0]});
                end
              end
            end
          end
        end
        default: begin
          clear_esc();
          plain_byte(b, last);
        end
      endcase
    endfunction

    function void note_input(logic [7:0] b, bit last);
      int        before_n;
      dec_beat_t tail;
      before_n = decoded_q.size();
      if (!err) decode_byte(b, last);
      if (last) begin
        // Close the string on its final beat, empty if nothing was decoded.
        if (decoded_q.size() == before_n) tail = '0;
        else tail = decoded_q.pop_back();
        tail.status = err;
        tail.done = 1'b1;
        decoded_q.push_back(tail);
        clear_esc();
        err = 0;
      end
    endfunction

    function void check_beat(logic [7:0] data, logic [1:0] user, logic tlast);
      dec_beat_t want;
      if (decoded_q.size() == 0) begin
        $error("unexpected result beat: out_byte %02h tuser %b tlast %b", data, user, tlast);
        errors++;
        return;
      end
      want = decoded_q.pop_front();
      if (data !== want.data) begin
        $error("out_byte: expected %02h, actual %02h", want.data, data);
        errors++;
      end
      if (user[0] !== want.byte_valid) begin
        $error("byte_valid: expected %b, actual %b", want.byte_valid, user[0]);
        errors++;
      end
      if (user[1] !== want.status) begin
        $error("status: expected %b, actual %b", want.status, user[1]);
        errors++;
      end
      if (tlast !== want.done) begin
        $error("string_done: expected %b, actual %b", want.done, tlast);
        errors++;
      end
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_tvalid = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata = '0;
  logic       in_tlast = 1'b0;
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;
  logic [1:0] out_tuser;
  logic       out_tlast;

  bit              steady = 0;
  int              items_sent = 0;
  int              quiet_cycles = 0;
  logic [7:0]      str_bytes[$];
  decode_scoreboard sb = new();

  c_string_escape_decoder u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Result side: random backpressure, check every accepted beat.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_beat(out_tdata, out_tuser, out_tlast);
    out_tready <= steady || ($urandom_range(0, 99) >= IdlePct);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("c_string_escape_decoder test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Send str_bytes as one string, tlast on the final beat.
  task automatic send_bytes();
    int n;
    n = str_bytes.size();
    for (int i = 0; i < n; i++) begin
      while (!steady && $urandom_range(0, 99) < IdlePct) begin
        in_tvalid <= 1'b0;
        @(posedge clk);
      end
      in_tvalid <= 1'b1;
      in_tdata  <= str_bytes[i];
      in_tlast  <= (i == n - 1);
      do @(posedge clk); while (!in_tready);
      sb.note_input(str_bytes[i], i == n - 1);
      items_sent++;
      steady <= (items_sent >= 200 && items_sent < 320);
    end
  endtask

  task automatic send_text(input string s);
    str_bytes.delete();
    for (int i = 0; i < s.len(); i++) str_bytes.push_back(s[i]);
    send_bytes();
  endtask

  task automatic put_hex(input logic [31:0] v, input int nd);
    logic [3:0] nib;
    for (int i = nd - 1; i >= 0; i--) begin
      nib = v[4*i +: 4];
      if (nib < 4'd10) str_bytes.push_back(8'h30 + {4'd0, nib});
      else if ($urandom_range(0, 1) == 1) str_bytes.push_back(8'h57 + {4'd0, nib});
      else str_bytes.push_back(8'h37 + {4'd0, nib});
    end
  endtask

  // Mostly well-formed escapes with random content, some noise and cut-off strings.
  task automatic compose_string();
    int          kind;
    int          keep;
    logic [7:0]  b;
    logic [31:0] cp;
    string       letters;
    letters = "?'\"\\abfnrtv";
    str_bytes.delete();
    repeat ($urandom_range(1, 6)) begin
      kind = $urandom_range(0, 99);
      if (kind < 35) begin
        b = 8'($urandom_range(0, 255));
        if (b == Bslash) b = "A";
        str_bytes.push_back(b);
      end else if (kind < 50) begin
        str_bytes.push_back(Bslash);
        str_bytes.push_back(letters[$urandom_range(0, 10)]);
      end else if (kind < 60) begin
        str_bytes.push_back(Bslash);
        repeat ($urandom_range(1, 3)) str_bytes.push_back(8'h30 + 8'($urandom_range(0, 7)));
      end else if (kind < 70) begin
        str_bytes.push_back(Bslash);
        str_bytes.push_back("x");
        put_hex($urandom, ($urandom_range(0, 7) == 0) ? 3 : $urandom_range(1, 2));
      end else if (kind < 80) begin
        case ($urandom_range(0, 9))
          0: cp = ($urandom_range(0, 2) == 0) ? CpDollar :
                  ($urandom_range(0, 1) == 0) ? CpAt : CpGrave;
          1: cp = $urandom_range(0, 32'h9F);
          2: cp = CpSurLo + $urandom_range(0, 32'h7FF);
          3, 4, 5: cp = $urandom_range(32'hA0, 32'h7FF);
          default: cp = $urandom_range(32'h800, 32'hFFFF);
        endcase
        str_bytes.push_back(Bslash);
        str_bytes.push_back("u");
        put_hex(cp, 4);
      end else if (kind < 88) begin
        case ($urandom_range(0, 9))
          0: cp = $urandom;
          1: cp = CpSurLo + $urandom_range(0, 32'h7FF);
          2: cp = $urandom_range(0, 32'hFFFF);
          default: cp = $urandom_range(32'h10000, CpMax);
        endcase
        str_bytes.push_back(Bslash);
        str_bytes.push_back("U");
        put_hex(cp, 8);
      end else if (kind < 94) begin
        // Unicode escape broken by a non-hex byte.
        str_bytes.push_back(Bslash);
        str_bytes.push_back(($urandom_range(0, 1) == 1) ? "u" : "U");
        put_hex($urandom, $urandom_range(0, 3));
        case ($urandom_range(0, 3))
          0: str_bytes.push_back("g");
          1: str_bytes.push_back("Z");
          2: str_bytes.push_back(" ");
          default: str_bytes.push_back(8'($urandom_range(128, 255)));
        endcase
      end else begin
        if ($urandom_range(0, 1) == 1) str_bytes.push_back(Bslash);
        str_bytes.push_back(8'($urandom_range(0, 255)));
      end
    end
    if ($urandom_range(0, 7) == 0) begin
      keep = $urandom_range(1, str_bytes.size());
      while (str_bytes.size() > keep) void'(str_bytes.pop_back());
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    str_bytes = '{8'h00, 8'hFF};
    send_bytes();
    send_text("\\");
    send_text("\\1\\n");
    send_text("\\777");
    send_text("\\x412");
    send_text("\\x");
    send_text("\\q");
    send_text("\\uD800");
    send_text("\\U0001F600");

    while (items_sent < ItemTarget) begin
      compose_string();
      send_bytes();
    end
    in_tvalid <= 1'b0;

    while (sb.decoded_q.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (sb.errors == 0 && sb.decoded_q.size() == 0) begin
      $display("c_string_escape_decoder test passed");
    end else begin
      $display("c_string_escape_decoder test failed");
    end
    $finish;
  end

endmodule
